@@ hw/rtl/kcl_pkg.sv @@
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types, key codes, register indexes and lookup tables for the
// keypad code lock and LED bar sequencer.
// ----------------------------------------------------------------------------
package kcl_pkg;

    typedef enum logic [1:0] {
        LOCK_LOCKED    = 2'd0,
        LOCK_UNLOCKING = 2'd1,
        LOCK_UNLOCKED  = 2'd2
    } lock_mode_t;

    // item command codes
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // key codes
    localparam logic [3:0] KEY_LAST_PATTERN = 4'd7;
    localparam logic [3:0] KEY_A            = 4'd10;
    localparam logic [3:0] KEY_B            = 4'd11;
    localparam logic [3:0] KEY_D            = 4'd13;

    // configuration register indexes
    localparam logic [2:0] CFG_CODE_FIRST  = 3'd0;
    localparam logic [2:0] CFG_CODE_SECOND = 3'd1;
    localparam logic [2:0] CFG_CODE_THIRD  = 3'd2;
    localparam logic [2:0] CFG_CODE_FOURTH = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT     = 3'd4;

    localparam logic [3:0] NO_PATTERN     = 4'd8;
    localparam logic [3:0] PREV_NONE      = 4'd9;
    localparam logic [3:0] PATTERN_ALWAYS = 4'd0;

    // rate held in quarters
    localparam logic [2:0] RATE_QUARTER   = 3'd1;
    localparam logic [2:0] RATE_HALF      = 3'd2;
    localparam logic [2:0] RATE_UNITY     = 3'd4;
    localparam logic [2:0] RATE_ONE_HALF  = 3'd6;

    localparam int         INTERVAL_W     = 22;
    localparam int         INTERVAL_SHIFT = 11;
    localparam int         PROD_W         = INTERVAL_W - INTERVAL_SHIFT;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 22'd32768;

    localparam logic [7:0] BAR_ALT_HI   = 8'hAA;
    localparam logic [7:0] BAR_ALT_LO   = 8'h55;
    localparam logic [7:0] BAR_ALL      = 8'hFF;
    localparam logic [7:0] BAR_TOP      = 8'h80;
    localparam logic [7:0] BAR_BOTTOM   = 8'h01;
    localparam logic [2:0] BOUNCE_LAST  = 3'd5;

    typedef struct packed {
        logic       step;
        logic       restart;
        logic [3:0] pattern;
    } pat_ctrl_t;

    typedef struct packed {
        logic       is_pattern;
        logic       has_rate;
        logic [2:0] rate;
        logic [7:0] bar;
    } pat_out_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    function automatic logic [7:0] bounce_value(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h18;
            3'd1:    v = 8'h24;
            3'd2:    v = 8'h42;
            3'd3:    v = 8'h81;
            3'd4:    v = 8'h42;
            3'd5:    v = 8'h24;
            default: v = 8'h18;
        endcase
        return v;
    endfunction

    function automatic rgb_t pattern_colour(input logic [3:0] pattern);
        rgb_t c;
        unique case (pattern)
            4'd0:    c = '{red: 8'd1,   green: 8'd254, blue: 8'd1};
            4'd1:    c = '{red: 8'd130, green: 8'd1,   blue: 8'd254};
            4'd2:    c = '{red: 8'd254, green: 8'd10,  blue: 8'd130};
            4'd3:    c = '{red: 8'd230, green: 8'd90,  blue: 8'd254};
            4'd4:    c = '{red: 8'd110, green: 8'd75,  blue: 8'd1};
            4'd5:    c = '{red: 8'd50,  green: 8'd4,   blue: 8'd254};
            4'd6:    c = '{red: 8'd254, green: 8'd20,  blue: 8'd35};
            4'd7:    c = '{red: 8'd35,  green: 8'd200, blue: 8'd150};
            default: c = '{red: 8'd1,   green: 8'd1,   blue: 8'd254};
        endcase
        return c;
    endfunction

    function automatic rgb_t lock_colour(input lock_mode_t mode, input logic [3:0] pattern);
        rgb_t c;
        unique case (mode)
            LOCK_LOCKED:    c = '{red: 8'd254, green: 8'd1,  blue: 8'd1};
            LOCK_UNLOCKING: c = '{red: 8'd254, green: 8'd20, blue: 8'd1};
            LOCK_UNLOCKED:  c = pattern_colour(pattern);
            default:        c = '{red: 8'd0,   green: 8'd0,  blue: 8'd0};
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/kcl_pattern_seq.sv @@
// ----------------------------------------------------------------------------
// kcl_pattern_seq
// Holds the sequence state of the seven stepping bar patterns; steps the selected
// pattern on a tick and restarts it on request.
// ----------------------------------------------------------------------------
module kcl_pattern_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  kcl_pkg::pat_ctrl_t  ctrl,
    output kcl_pkg::pat_out_t   status
);

    logic [7:0] toggle_reg, up_reg, down_reg, walk_one_reg, fill_reg;
    logic [2:0] bounce_reg, walk_zero_reg;

    logic [7:0] toggle_next, up_next, down_next, walk_one_next, fill_next;
    logic [2:0] bounce_next, walk_zero_next;
    logic [2:0] bounce_idx;
    logic [7:0] walk_zero_bar;

    // stepped value of each of patterns 1 to 7, in parallel
    always_comb
    begin
        toggle_next    = (toggle_reg == kcl_pkg::BAR_ALT_LO) ? kcl_pkg::BAR_ALT_HI
                                                             : kcl_pkg::BAR_ALT_LO;
        up_next        = (up_reg != kcl_pkg::BAR_ALL) ? up_reg + 8'd1 : 8'd0;
        bounce_idx     = (bounce_reg <= kcl_pkg::BOUNCE_LAST) ? bounce_reg : 3'd0;
        bounce_next    = (bounce_idx == kcl_pkg::BOUNCE_LAST) ? 3'd0 : bounce_idx + 3'd1;
        down_next      = (down_reg == 8'd0) ? kcl_pkg::BAR_ALL : down_reg - 8'd1;
        walk_one_next  = (walk_one_reg == 8'd0 || walk_one_reg == kcl_pkg::BAR_TOP)
                         ? kcl_pkg::BAR_BOTTOM : {walk_one_reg[6:0], 1'b0};
        walk_zero_bar  = ~(kcl_pkg::BAR_TOP >> walk_zero_reg);
        walk_zero_next = walk_zero_reg + 3'd1;
        fill_next      = (fill_reg != kcl_pkg::BAR_ALL) ? {fill_reg[6:0], 1'b1}
                                                        : kcl_pkg::BAR_BOTTOM;
    end

    always_comb
    begin
        status.is_pattern = 1'b1;
        status.has_rate   = 1'b1;
        status.rate       = kcl_pkg::RATE_UNITY;
        status.bar        = 8'd0;
        unique case (ctrl.pattern)
            4'd0:
            begin
                status.has_rate = 1'b0;
                status.bar      = kcl_pkg::BAR_ALT_HI;
            end
            4'd1:
            begin
                status.rate = kcl_pkg::RATE_UNITY;
                status.bar  = toggle_next;
            end
            4'd2:
            begin
                status.rate = kcl_pkg::RATE_HALF;
                status.bar  = up_next;
            end
            4'd3:
            begin
                status.rate = kcl_pkg::RATE_HALF;
                status.bar  = kcl_pkg::bounce_value(bounce_idx);
            end
            4'd4:
            begin
                status.rate = kcl_pkg::RATE_QUARTER;
                status.bar  = down_next;
            end
            4'd5:
            begin
                status.rate = kcl_pkg::RATE_ONE_HALF;
                status.bar  = walk_one_next;
            end
            4'd6:
            begin
                status.rate = kcl_pkg::RATE_HALF;
                status.bar  = walk_zero_bar;
            end
            4'd7:
            begin
                status.rate = kcl_pkg::RATE_UNITY;
                status.bar  = fill_next;
            end
            default:
            begin
                status.is_pattern = 1'b0;
                status.has_rate   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_reg    <= 8'd0;
            up_reg        <= 8'd0;
            bounce_reg    <= 3'd0;
            down_reg      <= 8'd0;
            walk_one_reg  <= 8'd0;
            walk_zero_reg <= 3'd0;
            fill_reg      <= 8'd0;
        end
        else if (ctrl.restart)
        begin
            unique case (ctrl.pattern)
                4'd1:    toggle_reg    <= kcl_pkg::BAR_ALT_LO;
                4'd2:    up_reg        <= kcl_pkg::BAR_ALL;
                4'd3:    bounce_reg    <= 3'd0;
                4'd4:    down_reg      <= 8'd0;
                4'd5:    walk_one_reg  <= kcl_pkg::BAR_TOP;
                4'd6:    walk_zero_reg <= 3'd0;
                4'd7:    fill_reg      <= kcl_pkg::BAR_ALL;
                default: ;
            endcase
        end
        else if (ctrl.step)
        begin
            unique case (ctrl.pattern)
                4'd1:    toggle_reg    <= toggle_next;
                4'd2:    up_reg        <= up_next;
                4'd3:    bounce_reg    <= bounce_next;
                4'd4:    down_reg      <= down_next;
                4'd5:    walk_one_reg  <= walk_one_next;
                4'd6:    walk_zero_reg <= walk_zero_next;
                4'd7:    fill_reg      <= fill_next;
                default: ;
            endcase
        end
    end

endmodule

@@ hw/rtl/keypad_code_lock_led_sequencer.sv @@
// ----------------------------------------------------------------------------
// keypad_code_lock_led_sequencer
// Four-key code lock with unlock timeout, LED bar pattern sequencer and
// RGB colour selection; one result per key press or timer tick.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the input register, then the state and
//   result registers are updated together and out_valid rises; a stalled result
//   holds the input register. Throughput: one item per cycle unless the result
//   stalls; the whole update is a single pass of logic.
// Reset: locked, no pattern, period 4, rate 1.0, interval 32768, code 5-2-9-3,
//   timeout 5 ticks; both channels empty.
module keypad_code_lock_led_sequencer #(
    parameter int PERIOD_MAX = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [3:0]  key_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  lock_state,
    output logic [3:0]  pattern_select,
    output logic [7:0]  led_bar,
    output logic [21:0] interval_count,
    output logic [7:0]  red_duty,
    output logic [7:0]  green_duty,
    output logic [7:0]  blue_duty,
    output logic [2:0]  keys_matched,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int PW_RAW = $clog2(PERIOD_MAX + 1);
    localparam int PW     = (PW_RAW > 3) ? PW_RAW : 3;
    localparam logic [PW-1:0] PERIOD_TOP   = PW'(PERIOD_MAX);
    localparam logic [PW-1:0] PERIOD_RESET = PW'(4);
    localparam logic [PW-1:0] PERIOD_ONE   = PW'(1);

    // configuration
    logic [3:0] code_first_reg, code_second_reg, code_third_reg, code_fourth_reg;
    logic [3:0] timeout_reg;

    // input stage
    logic       in_vld_reg, cmd_reg;
    logic [3:0] key_reg;
    logic       advance, is_tick;

    // output stage
    logic         out_vld_reg;
    kcl_pkg::rgb_t duty_reg, duty_next;

    // lock and sequencer state
    kcl_pkg::lock_mode_t mode_reg, mode_next;
    logic [2:0]  matched_reg, matched_next;
    logic        armed_reg, armed_next;
    logic [3:0]  ticks_reg, ticks_next;
    logic [3:0]  pat_reg, pat_next;
    logic [3:0]  prev_reg, prev_next;
    logic [PW-1:0] period_reg, period_next;
    logic [2:0]  rate_reg, rate_next;
    logic [7:0]  bar_reg, bar_next;
    logic [kcl_pkg::INTERVAL_W-1:0] interval_reg, interval_next;

    // key path
    kcl_pkg::lock_mode_t k_mode;
    logic [2:0]  k_matched;
    logic        k_armed, k_restart, k_known;
    logic [3:0]  k_ticks, k_pat, k_want;
    logic [PW-1:0] k_period;

    // tick path
    kcl_pkg::lock_mode_t t_mode;
    logic        t_armed;
    logic [3:0]  t_ticks;
    logic [2:0]  t_rate;
    logic [7:0]  t_bar;
    logic [kcl_pkg::INTERVAL_W-1:0] t_interval;
    logic [kcl_pkg::PROD_W-1:0]     t_product;

    kcl_pkg::pat_ctrl_t pat_ctrl;
    kcl_pkg::pat_out_t  pat_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_first_reg  <= 4'd5;
            code_second_reg <= 4'd2;
            code_third_reg  <= 4'd9;
            code_fourth_reg <= 4'd3;
            timeout_reg     <= 4'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                kcl_pkg::CFG_CODE_FIRST:  code_first_reg  <= cfg_data;
                kcl_pkg::CFG_CODE_SECOND: code_second_reg <= cfg_data;
                kcl_pkg::CFG_CODE_THIRD:  code_third_reg  <= cfg_data;
                kcl_pkg::CFG_CODE_FOURTH: code_fourth_reg <= cfg_data;
                kcl_pkg::CFG_TIMEOUT:     timeout_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance when the result register is free or being drained
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign is_tick  = (cmd_reg == kcl_pkg::CMD_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg <= command;
            key_reg <= key_code;
        end
    end

    // key press: unlocked, then unlocking, then locked stage on the same key
    always_comb
    begin
        k_mode    = mode_reg;
        k_matched = matched_reg;
        k_armed   = armed_reg;
        k_ticks   = ticks_reg;
        k_pat     = pat_reg;
        k_period  = period_reg;
        k_restart = 1'b0;
        k_known   = 1'b1;
        k_want    = code_second_reg;

        if (k_mode == kcl_pkg::LOCK_UNLOCKED)
        begin
            if (key_reg <= kcl_pkg::KEY_LAST_PATTERN)
            begin
                k_pat = key_reg;
            end
            if (key_reg == kcl_pkg::KEY_A)
            begin
                k_period = (k_period > PERIOD_ONE) ? k_period - PERIOD_ONE : PERIOD_ONE;
            end
            if (key_reg == kcl_pkg::KEY_B && k_period < PERIOD_TOP)
            begin
                k_period = k_period + PERIOD_ONE;
            end
            if (key_reg == kcl_pkg::KEY_D)
            begin
                k_mode   = kcl_pkg::LOCK_LOCKED;
                k_pat    = kcl_pkg::NO_PATTERN;
                k_period = PERIOD_RESET;
                k_ticks  = timeout_reg;
                k_armed  = 1'b0;
            end
        end

        if (k_mode == kcl_pkg::LOCK_UNLOCKING)
        begin
            unique case (k_matched)
                3'd1:    k_want = code_second_reg;
                3'd2:    k_want = code_third_reg;
                3'd3:    k_want = code_fourth_reg;
                default: k_known = 1'b0;
            endcase
            if (k_known)
            begin
                if (key_reg == k_want)
                begin
                    k_matched = k_matched + 3'd1;
                    if (k_matched == 3'd4)
                    begin
                        k_mode  = kcl_pkg::LOCK_UNLOCKED;
                        k_armed = 1'b0;
                    end
                end
                else
                begin
                    k_mode    = kcl_pkg::LOCK_LOCKED;
                    k_matched = 3'd0;
                    k_armed   = 1'b0;
                end
            end
        end

        // a wrong key falls through here and may start a fresh entry
        if (k_mode == kcl_pkg::LOCK_LOCKED)
        begin
            if (key_reg == code_first_reg)
            begin
                k_mode    = kcl_pkg::LOCK_UNLOCKING;
                k_matched = 3'd1;
            end
            else
            begin
                k_matched = 3'd0;
                k_pat     = kcl_pkg::NO_PATTERN;
            end
        end

        if (k_mode == kcl_pkg::LOCK_UNLOCKED && k_pat == prev_reg)
        begin
            k_restart = 1'b1;
        end
    end

    assign pat_ctrl.step    = advance && is_tick && (mode_reg == kcl_pkg::LOCK_UNLOCKED);
    assign pat_ctrl.restart = advance && !is_tick && k_restart;
    assign pat_ctrl.pattern = is_tick ? pat_reg : k_pat;

    kcl_pattern_seq u_pattern (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (pat_ctrl),
        .status (pat_status)
    );

    // tick: run the unlock timeout, then step the pattern
    always_comb
    begin
        t_mode     = mode_reg;
        t_armed    = armed_reg;
        t_ticks    = ticks_reg;
        t_rate     = rate_reg;
        t_bar      = bar_reg;
        t_interval = interval_reg;
        t_product  = '0;

        if (t_mode == kcl_pkg::LOCK_UNLOCKING)
        begin
            if (matched_reg == 3'd1 && !armed_reg)
            begin
                t_interval = kcl_pkg::INTERVAL_RESET;
                t_rate     = kcl_pkg::RATE_UNITY;
                t_armed    = 1'b1;
                t_ticks    = timeout_reg;
            end
            if (t_ticks != 4'd0)
            begin
                t_ticks = t_ticks - 4'd1;
            end
            else
            begin
                t_mode  = kcl_pkg::LOCK_LOCKED;
                t_armed = 1'b0;
            end
        end

        if (t_mode == kcl_pkg::LOCK_UNLOCKED)
        begin
            if (pat_status.is_pattern)
            begin
                t_bar = pat_status.bar;
            end
            if (pat_status.has_rate)
            begin
                t_rate = pat_status.rate;
            end
            t_product  = kcl_pkg::PROD_W'(t_rate) * kcl_pkg::PROD_W'(period_reg);
            t_interval = {t_product, {kcl_pkg::INTERVAL_SHIFT{1'b0}}};
        end
        else
        begin
            t_bar = 8'd0;
        end
    end

    // next state
    always_comb
    begin
        if (is_tick)
        begin
            mode_next     = t_mode;
            matched_next  = matched_reg;
            armed_next    = t_armed;
            ticks_next    = t_ticks;
            pat_next      = pat_reg;
            prev_next     = prev_reg;
            period_next   = period_reg;
            rate_next     = t_rate;
            bar_next      = t_bar;
            interval_next = t_interval;
        end
        else
        begin
            mode_next     = k_mode;
            matched_next  = k_matched;
            armed_next    = k_armed;
            ticks_next    = k_ticks;
            pat_next      = k_pat;
            prev_next     = (k_mode == kcl_pkg::LOCK_UNLOCKED) ? k_pat : prev_reg;
            period_next   = k_period;
            rate_next     = rate_reg;
            bar_next      = bar_reg;
            interval_next = interval_reg;
        end
    end

    // result colour
    always_comb
    begin
        duty_next = kcl_pkg::lock_colour(mode_next, pat_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= kcl_pkg::LOCK_LOCKED;
            matched_reg  <= 3'd0;
            armed_reg    <= 1'b0;
            ticks_reg    <= 4'd5;
            pat_reg      <= kcl_pkg::NO_PATTERN;
            prev_reg     <= kcl_pkg::PREV_NONE;
            period_reg   <= PERIOD_RESET;
            rate_reg     <= kcl_pkg::RATE_UNITY;
            bar_reg      <= 8'd0;
            interval_reg <= kcl_pkg::INTERVAL_RESET;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            matched_reg  <= matched_next;
            armed_reg    <= armed_next;
            ticks_reg    <= ticks_next;
            pat_reg      <= pat_next;
            prev_reg     <= prev_next;
            period_reg   <= period_next;
            rate_reg     <= rate_next;
            bar_reg      <= bar_next;
            interval_reg <= interval_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            duty_reg <= duty_next;
        end
    end

    assign out_valid      = out_vld_reg;
    assign lock_state     = mode_reg;
    assign pattern_select = pat_reg;
    assign led_bar        = bar_reg;
    assign interval_count = interval_reg;
    assign red_duty       = duty_reg.red;
    assign green_duty     = duty_reg.green;
    assign blue_duty      = duty_reg.blue;
    assign keys_matched   = matched_reg;

    // checks
    a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("result register not loaded after advance");

    a_unlocking_count: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == kcl_pkg::LOCK_UNLOCKING |->
            (matched_reg == 3'd1 || matched_reg == 3'd2 || matched_reg == 3'd3))
        else $error("unlocking with an impossible match count");

    a_unlocked_full: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == kcl_pkg::LOCK_UNLOCKED |-> matched_reg == 3'd4)
        else $error("unlocked without the full code matched");

    a_armed_unlocking: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> mode_reg == kcl_pkg::LOCK_UNLOCKING)
        else $error("timeout armed outside unlocking");

    a_pattern_locked: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != kcl_pkg::LOCK_UNLOCKED |-> pat_reg == kcl_pkg::NO_PATTERN)
        else $error("pattern selected while not unlocked");

endmodule

@@ bench/keypad_code_lock_led_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// keypad_code_lock_led_sequencer_tb
// Self-checking bench for the code lock and LED bar sequencer. Drives key
// presses and timer ticks through the stall handshake and tracks the lock,
// pattern and colour state in a local model. Each result transfer is
// compared field by field against the oldest prediction. Directed code
// entry and pattern tours come first, then timeout and period limits under
// rewritten registers, then random sessions.
// ----------------------------------------------------------------------------
module keypad_code_lock_led_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         PERIOD_LIMIT = 255;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         IDLE_PCT     = 37;
    localparam logic [3:0] KEY_C        = 4'd12;
    localparam logic [3:0] KEY_STAR     = 4'd14;
    localparam logic [3:0] KEY_HASH     = 4'd15;

    typedef struct packed {
        logic [1:0]  lock;
        logic [3:0]  pattern;
        logic [7:0]  bar;
        logic [21:0] interval;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [2:0]  matched;
    } lock_view_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = kcl_pkg::CMD_KEY;
    logic [3:0]  key_code = 4'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  lock_state;
    logic [3:0]  pattern_select;
    logic [7:0]  led_bar;
    logic [21:0] interval_count;
    logic [7:0]  red_duty;
    logic [7:0]  green_duty;
    logic [7:0]  blue_duty;
    logic [2:0]  keys_matched;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = kcl_pkg::CFG_CODE_FIRST;
    logic [3:0]  cfg_data = 4'd0;

    // lock model state
    logic [3:0]  code_key [4];
    logic [3:0]  timeout_cfg;
    kcl_pkg::lock_mode_t lk_mode;
    logic [2:0]  keys_ok;
    logic        armed;
    logic [3:0]  ticks_rem;
    logic [3:0]  pat;
    logic [3:0]  prev_pat;
    logic [7:0]  period;
    logic [2:0]  quarters;
    logic [7:0]  toggle;
    logic [7:0]  up;
    logic [2:0]  bounce;
    logic [7:0]  down;
    logic [7:0]  walk1;
    logic [2:0]  walk0;
    logic [7:0]  fill;
    logic [7:0]  bar;
    logic [21:0] interval;

    lock_view_t  pending_views [$];
    int          mismatches = 0;
    int          item_count = 0;
    int          cycle_count = 0;
    bit          steady = 1'b0;

    keypad_code_lock_led_sequencer #(
        .PERIOD_MAX(PERIOD_LIMIT)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .key_code      (key_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .lock_state    (lock_state),
        .pattern_select(pattern_select),
        .led_bar       (led_bar),
        .interval_count(interval_count),
        .red_duty      (red_duty),
        .green_duty    (green_duty),
        .blue_duty     (blue_duty),
        .keys_matched  (keys_matched),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    always @(negedge clk)
    begin
        out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end

    function automatic void reset_lock_model();
        code_key[0] = 4'd5;
        code_key[1] = 4'd2;
        code_key[2] = 4'd9;
        code_key[3] = 4'd3;
        timeout_cfg = 4'd5;
        lk_mode     = kcl_pkg::LOCK_LOCKED;
        keys_ok     = 3'd0;
        armed       = 1'b0;
        ticks_rem   = 4'd5;
        pat         = kcl_pkg::NO_PATTERN;
        prev_pat    = kcl_pkg::PREV_NONE;
        period      = 8'd4;
        quarters    = kcl_pkg::RATE_UNITY;
        toggle      = 8'd0;
        up          = 8'd0;
        bounce      = 3'd0;
        down        = 8'd0;
        walk1       = 8'd0;
        walk0       = 3'd0;
        fill        = 8'd0;
        bar         = 8'd0;
        interval    = kcl_pkg::INTERVAL_RESET;
    endfunction

    function automatic void restart_sequence(input logic [3:0] p);
        case (p)
            4'd1:    toggle = kcl_pkg::BAR_ALT_LO;
            4'd2:    up = kcl_pkg::BAR_ALL;
            4'd3:    bounce = 3'd0;
            4'd4:    down = 8'd0;
            4'd5:    walk1 = kcl_pkg::BAR_TOP;
            4'd6:    walk0 = 3'd0;
            4'd7:    fill = kcl_pkg::BAR_ALL;
            default: ;
        endcase
    endfunction

    function automatic void apply_key(input logic [3:0] k);
        if (lk_mode == kcl_pkg::LOCK_UNLOCKED)
        begin
            if (k <= kcl_pkg::KEY_LAST_PATTERN)
                pat = k;
            if (k == kcl_pkg::KEY_A && period > 8'd1)
                period = period - 8'd1;
            if (k == kcl_pkg::KEY_B && period < PERIOD_LIMIT)
                period = period + 8'd1;
            if (k == kcl_pkg::KEY_D)
            begin
                lk_mode   = kcl_pkg::LOCK_LOCKED;
                pat       = kcl_pkg::NO_PATTERN;
                period    = 8'd4;
                ticks_rem = timeout_cfg;
                armed     = 1'b0;
            end
        end
        if (lk_mode == kcl_pkg::LOCK_UNLOCKING && keys_ok >= 3'd1 && keys_ok <= 3'd3)
        begin
            if (k == code_key[keys_ok[1:0]])
            begin
                keys_ok = keys_ok + 3'd1;
                if (keys_ok == 3'd4)
                begin
                    lk_mode = kcl_pkg::LOCK_UNLOCKED;
                    armed   = 1'b0;
                end
            end
            else
            begin
                lk_mode = kcl_pkg::LOCK_LOCKED;
                keys_ok = 3'd0;
                armed   = 1'b0;
            end
        end
        // a wrong key that relocked is checked again as a first key
        if (lk_mode == kcl_pkg::LOCK_LOCKED)
        begin
            if (k == code_key[0])
            begin
                lk_mode = kcl_pkg::LOCK_UNLOCKING;
                keys_ok = 3'd1;
            end
            else
            begin
                keys_ok = 3'd0;
                pat     = kcl_pkg::NO_PATTERN;
            end
        end
        if (lk_mode == kcl_pkg::LOCK_UNLOCKED)
        begin
            if (pat == prev_pat)
                restart_sequence(pat);
            prev_pat = pat;
        end
    endfunction

    function automatic void apply_tick();
        logic [31:0] product;
        logic [2:0]  s;
        if (lk_mode == kcl_pkg::LOCK_UNLOCKING)
        begin
            if (keys_ok == 3'd1 && !armed)
            begin
                interval  = kcl_pkg::INTERVAL_RESET;
                quarters  = kcl_pkg::RATE_UNITY;
                armed     = 1'b1;
                ticks_rem = timeout_cfg;
            end
            if (ticks_rem != 4'd0)
                ticks_rem = ticks_rem - 4'd1;
            else
            begin
                // relock but keep the matched count
                lk_mode = kcl_pkg::LOCK_LOCKED;
                armed   = 1'b0;
            end
        end
        if (lk_mode == kcl_pkg::LOCK_UNLOCKED)
        begin
            case (pat)
                4'd0: bar = kcl_pkg::BAR_ALT_HI;
                4'd1:
                begin
                    quarters = kcl_pkg::RATE_UNITY;
                    toggle   = (toggle == kcl_pkg::BAR_ALT_LO) ? kcl_pkg::BAR_ALT_HI
                                                               : kcl_pkg::BAR_ALT_LO;
                    bar      = toggle;
                end
                4'd2:
                begin
                    quarters = kcl_pkg::RATE_HALF;
                    up       = (up != kcl_pkg::BAR_ALL) ? up + 8'd1 : 8'd0;
                    bar      = up;
                end
                4'd3:
                begin
                    s        = (bounce <= kcl_pkg::BOUNCE_LAST) ? bounce : 3'd0;
                    quarters = kcl_pkg::RATE_HALF;
                    case (s)
                        3'd1, 3'd5: bar = 8'h24;
                        3'd2, 3'd4: bar = 8'h42;
                        3'd3:       bar = 8'h81;
                        default:    bar = 8'h18;
                    endcase
                    bounce   = (s == kcl_pkg::BOUNCE_LAST) ? 3'd0 : s + 3'd1;
                end
                4'd4:
                begin
                    quarters = kcl_pkg::RATE_QUARTER;
                    down     = (down == 8'd0) ? kcl_pkg::BAR_ALL : down - 8'd1;
                    bar      = down;
                end
                4'd5:
                begin
                    quarters = kcl_pkg::RATE_ONE_HALF;
                    if (walk1 == 8'd0 || walk1 == kcl_pkg::BAR_TOP)
                        walk1 = kcl_pkg::BAR_BOTTOM;
                    else
                        walk1 = walk1 << 1;
                    bar      = walk1;
                end
                4'd6:
                begin
                    quarters = kcl_pkg::RATE_HALF;
                    bar      = ~(kcl_pkg::BAR_TOP >> walk0);
                    walk0    = walk0 + 3'd1;
                end
                4'd7:
                begin
                    quarters = kcl_pkg::RATE_UNITY;
                    fill     = (fill != kcl_pkg::BAR_ALL) ? {fill[6:0], 1'b1}
                                                          : kcl_pkg::BAR_BOTTOM;
                    bar      = fill;
                end
                default: ;
            endcase
            product  = 32'(quarters) * 32'd2048 * 32'(period);
            interval = product[21:0];
        end
        else
            bar = 8'd0;
    endfunction

    function automatic lock_view_t current_view();
        lock_view_t v;
        logic [23:0] rgb;
        case (lk_mode)
            kcl_pkg::LOCK_LOCKED:    rgb = {8'd254, 8'd1, 8'd1};
            kcl_pkg::LOCK_UNLOCKING: rgb = {8'd254, 8'd20, 8'd1};
            kcl_pkg::LOCK_UNLOCKED:
            begin
                case (pat)
                    4'd0:    rgb = {8'd1, 8'd254, 8'd1};
                    4'd1:    rgb = {8'd130, 8'd1, 8'd254};
                    4'd2:    rgb = {8'd254, 8'd10, 8'd130};
                    4'd3:    rgb = {8'd230, 8'd90, 8'd254};
                    4'd4:    rgb = {8'd110, 8'd75, 8'd1};
                    4'd5:    rgb = {8'd50, 8'd4, 8'd254};
                    4'd6:    rgb = {8'd254, 8'd20, 8'd35};
                    4'd7:    rgb = {8'd35, 8'd200, 8'd150};
                    default: rgb = {8'd1, 8'd1, 8'd254};
                endcase
            end
            default:        rgb = 24'd0;
        endcase
        v.lock     = lk_mode;
        v.pattern  = pat;
        v.bar      = bar;
        v.interval = interval;
        v.red      = rgb[23:16];
        v.green    = rgb[15:8];
        v.blue     = rgb[7:0];
        v.matched  = keys_ok;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin : result_check
        lock_view_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_views.size() == 0)
                report_mismatch("result with nothing pending, lock_state", lock_state, 0);
            else
            begin
                w = pending_views.pop_front();
                check_field("lock_state", lock_state, w.lock);
                check_field("pattern_select", pattern_select, w.pattern);
                check_field("led_bar", led_bar, w.bar);
                check_field("interval_count", interval_count, w.interval);
                check_field("red_duty", red_duty, w.red);
                check_field("green_duty", green_duty, w.green);
                check_field("blue_duty", blue_duty, w.blue);
                check_field("keys_matched", keys_matched, w.matched);
            end
        end
    end

    // hold the item until the transfer, then predict its result
    task automatic send_item(input logic cmd, input logic [3:0] key);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        key_code <= key;
        do
            @(posedge clk);
        while (in_stall);
        if (cmd == kcl_pkg::CMD_KEY)
            apply_key(key);
        else
            apply_tick();
        pending_views.push_back(current_view());
        item_count++;
    endtask

    task automatic press(input logic [3:0] key);
        send_item(kcl_pkg::CMD_KEY, key);
    endtask

    task automatic tick();
        send_item(kcl_pkg::CMD_TICK, 4'($urandom_range(0, 15)));
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            kcl_pkg::CFG_CODE_FIRST:  code_key[0] = val;
            kcl_pkg::CFG_CODE_SECOND: code_key[1] = val;
            kcl_pkg::CFG_CODE_THIRD:  code_key[2] = val;
            kcl_pkg::CFG_CODE_FOURTH: code_key[3] = val;
            kcl_pkg::CFG_TIMEOUT:     timeout_cfg = val;
            default:                  ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [3:0] k0, input logic [3:0] k1,
                              input logic [3:0] k2, input logic [3:0] k3,
                              input logic [3:0] t);
        settle();
        write_reg(kcl_pkg::CFG_CODE_FIRST, k0);
        write_reg(kcl_pkg::CFG_CODE_SECOND, k1);
        write_reg(kcl_pkg::CFG_CODE_THIRD, k2);
        write_reg(kcl_pkg::CFG_CODE_FOURTH, k3);
        write_reg(kcl_pkg::CFG_TIMEOUT, t);
    endtask

    // type the code, with optional ticks in between and corrupted digits
    task automatic enter_code(input int tick_pct, input int break_pct);
        for (int i = 0; i < 4; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                tick();
            if ($urandom_range(0, 99) < break_pct)
                press(4'($urandom_range(0, 15)));
            else
                press(code_key[2'(i)]);
        end
    endtask

    task automatic test_code_entry();
        send_item(kcl_pkg::CMD_TICK, KEY_HASH);
        press(KEY_HASH);
        press(4'd5);
        send_item(kcl_pkg::CMD_TICK, 4'd0);
        press(4'd2);
        press(4'd4);
        press(4'd5);
        press(4'd5);
        press(4'd2);
        press(4'd9);
        press(4'd3);
    endtask

    task automatic test_pattern_tour();
        tick();
        press(4'd0);
        tick();
        for (int p = 1; p <= kcl_pkg::KEY_LAST_PATTERN; p++)
        begin
            press(4'(p));
            tick();
        end
        press(kcl_pkg::KEY_LAST_PATTERN);
        press(kcl_pkg::KEY_A);
        tick();
        press(kcl_pkg::KEY_B);
        press(KEY_C);
        press(KEY_STAR);
        press(4'd8);
        press(kcl_pkg::KEY_D);
    endtask

    task automatic test_timeout_relock();
        set_config(4'd0, 4'd15, 4'd0, 4'd15, 4'd0);
        press(4'd0);
        tick();
        press(4'd0);
        press(4'd15);
        press(4'd0);
        press(4'd15);
        press(kcl_pkg::KEY_D);
        set_config(4'd15, 4'd0, 4'd15, 4'd0, 4'd15);
        press(4'd15);
        repeat (17) tick();
    endtask

    // drive the period to its ceiling and floor back to back, no idling
    task automatic test_period_limits();
        settle();
        steady = 1'b1;
        enter_code(0, 0);
        press(4'd5);
        repeat (253) press(kcl_pkg::KEY_B);
        tick();
        tick();
        repeat (256) press(kcl_pkg::KEY_A);
        tick();
        press(kcl_pkg::KEY_D);
        steady = 1'b0;
    endtask

    task automatic random_step();
        int r;
        r = $urandom_range(0, 99);
        if (lk_mode != kcl_pkg::LOCK_UNLOCKED)
        begin
            if (r < 75)
                enter_code(20, 8);
            else
                send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        end
        else if (r < 35)
            press(4'($urandom_range(0, kcl_pkg::KEY_LAST_PATTERN)));
        else if (r < 70)
            tick();
        else if (r < 78)
            press(kcl_pkg::KEY_A);
        else if (r < 86)
            press(kcl_pkg::KEY_B);
        else if (r < 95)
            press(4'($urandom_range(8, 15)));
        else
            press(kcl_pkg::KEY_D);
    endtask

    task automatic test_random_sessions(input int items_per_phase);
        int target;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_config(4'd15, 4'd15, 4'd15, 4'd15, 4'd15);
                1: set_config(4'd3, 4'd3, 4'd3, 4'd3, 4'd1);
                2: set_config(4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
                default: set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                    4'($urandom_range(0, 6)));
            endcase
            target = item_count + items_per_phase;
            while (item_count < target)
                random_step();
        end
    endtask

    initial
    begin
        reset_lock_model();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_code_entry();
        test_pattern_tour();
        test_timeout_relock();
        test_period_limits();
        test_random_sessions(150);

        settle();
        repeat (10) @(posedge clk);
        if (pending_views.size() != 0)
            report_mismatch("results still pending", pending_views.size(), 0);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
